// ----- hdl/psg_tone_noise_generator_assert.svh -----
// Assertion macros for the sound generator, all clocked on clk and held off during reset.
`ifndef PSG_TONE_NOISE_GENERATOR_ASSERT_SVH
`define PSG_TONE_NOISE_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge out of reset.
`define PSG_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("psg assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PSG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("psg assertion failed");

`else

`define PSG_ASSERT(lbl, prop)
`define PSG_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- hdl/psg_pkg.sv -----
package psg_pkg;

	localparam int NUM_TONES        = 3;
	localparam int NUM_CH           = 4;
	localparam int PERIOD_W         = 10;
	localparam int ATT_W            = 4;
	localparam int AMP_W            = 15;
	localparam int LEVEL_W          = 16;
	localparam int NOISE_W          = 16;
	localparam int NOISE_DIVIDE_DEF = 64;

	localparam logic [NOISE_W-1:0] NOISE_SEED = 16'h8000;

	// Register index of the noise control register; odd indexes are attenuations.
	localparam logic [2:0] REG_NOISE_CTRL = 3'd6;

	localparam logic [AMP_W-1:0] AMP_TABLE [16] = '{
		15'd32767, 15'd26028, 15'd20675, 15'd16422, 15'd13045, 15'd10362, 15'd8231, 15'd6568,
		15'd5193,  15'd4125,  15'd3277,  15'd2603,  15'd2067,  15'd1642,  15'd1304, 15'd0
	};

	typedef struct packed {
		logic [NUM_TONES-1:0][PERIOD_W-1:0] period;
		logic [NUM_CH-1:0][ATT_W-1:0]       atten;
		logic                               white;
		logic                               noise_rst;
	} psg_regs_t;

	typedef struct packed {
		logic              edge_hit;
		logic [NUM_CH-1:0] phase;
	} psg_gen_t;

endpackage

// ----- hdl/psg_in_if.sv -----
interface psg_in_if;
	logic       valid;
	logic       ready;
	logic       clock_level;
	logic       chip_enable_n;
	logic       write_enable_n;
	logic [7:0] bus_data;

	modport source (
		output valid, clock_level, chip_enable_n, write_enable_n, bus_data,
		input ready
	);
	modport sink (
		input valid, clock_level, chip_enable_n, write_enable_n, bus_data,
		output ready
	);
endinterface

// ----- hdl/psg_out_if.sv -----
interface psg_out_if;
	logic                         valid;
	logic                         ready;
	logic [psg_pkg::LEVEL_W-1:0] audio_level;

	modport source (
		output valid, audio_level,
		input ready
	);
	modport sink (
		input valid, audio_level,
		output ready
	);
endinterface

// ----- hdl/psg_regs.sv -----
module psg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                write_en,
	input  logic [7:0]          bus_data,
	output psg_pkg::psg_regs_t regs_nx
);

	logic [psg_pkg::NUM_TONES-1:0][psg_pkg::PERIOD_W-1:0] period_q;
	logic [psg_pkg::NUM_CH-1:0][psg_pkg::ATT_W-1:0]       atten_q;
	logic                                                   white_q;
	logic [2:0]                                             latched_q;
	logic [2:0]                                             latched_nx;
	logic [2:0]                                             reg_idx;

	always_comb begin
		regs_nx.period    = period_q;
		regs_nx.atten     = atten_q;
		regs_nx.white     = white_q;
		regs_nx.noise_rst = 1'b0;
		latched_nx        = latched_q;
		reg_idx           = bus_data[7] ? bus_data[6:4] : latched_q;
		if (accept && write_en) begin
			if (bus_data[7]) begin
				latched_nx = bus_data[6:4];
			end
			if (reg_idx == psg_pkg::REG_NOISE_CTRL) begin
				// data bytes to noise control are dropped
				if (bus_data[7]) begin
					regs_nx.white     = bus_data[2];
					regs_nx.noise_rst = 1'b1;
				end
			end else if (reg_idx[0]) begin
				for (int c = 0; c < psg_pkg::NUM_CH; c++) begin
					if (reg_idx[2:1] == 2'(c)) begin
						regs_nx.atten[c] = bus_data[3:0];
					end
				end
			end else begin
				for (int t = 0; t < psg_pkg::NUM_TONES; t++) begin
					if (reg_idx[2:1] == 2'(t)) begin
						if (bus_data[7]) begin
							regs_nx.period[t][3:0] = bus_data[3:0];
						end else begin
							regs_nx.period[t][9:4] = bus_data[5:0];
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= '0;
			atten_q   <= '0;
			white_q   <= 1'b0;
			latched_q <= '0;
		end else begin
			period_q  <= regs_nx.period;
			atten_q   <= regs_nx.atten;
			white_q   <= regs_nx.white;
			latched_q <= latched_nx;
		end
	end

endmodule

// ----- hdl/psg_gen.sv -----
module psg_gen #(
	parameter int NoiseDivide = psg_pkg::NOISE_DIVIDE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               clock_level,
	input  psg_pkg::psg_regs_t regs_nx,
	output psg_pkg::psg_gen_t  gen_nx
);

	localparam int PreW = $clog2(NoiseDivide + 1);

	logic [psg_pkg::NUM_TONES-1:0][psg_pkg::PERIOD_W-1:0] count_q;
	logic [psg_pkg::NUM_TONES-1:0][psg_pkg::PERIOD_W-1:0] count_nx;
	logic [psg_pkg::NUM_CH-1:0]                           phase_q;
	logic [psg_pkg::NOISE_W-1:0]                          shift_q;
	logic [psg_pkg::NOISE_W-1:0]                          shift_nx;
	logic [psg_pkg::NOISE_W-1:0]                          shift_base;
	logic [PreW-1:0]                                      prescale_q;
	logic [PreW-1:0]                                      prescale_nx;
	logic                                                 last_clock_q;
	logic                                                 feedback;

	always_comb begin
		gen_nx.edge_hit = clock_level != last_clock_q;
		gen_nx.phase    = phase_q;
		count_nx        = count_q;
		prescale_nx     = prescale_q;
		// a noise control latch reseeds before the shift on the same sample
		shift_base      = regs_nx.noise_rst ? psg_pkg::NOISE_SEED : shift_q;
		shift_nx        = shift_base;
		feedback        = regs_nx.white ? (shift_base[0] ^ shift_base[3]) : shift_base[0];
		if (gen_nx.edge_hit) begin
			for (int t = 0; t < psg_pkg::NUM_TONES; t++) begin
				if (count_q[t] == '0) begin
					count_nx[t]     = regs_nx.period[t];
					gen_nx.phase[t] = !phase_q[t];
				end else begin
					count_nx[t] = count_q[t] - 1'b1;
				end
			end
			if (prescale_q == PreW'(NoiseDivide)) begin
				gen_nx.phase[psg_pkg::NUM_CH-1] = shift_base[0];
				shift_nx    = {feedback, shift_base[psg_pkg::NOISE_W-1:1]};
				prescale_nx = '0;
			end else begin
				prescale_nx = prescale_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			phase_q      <= '0;
			shift_q      <= psg_pkg::NOISE_SEED;
			prescale_q   <= '0;
			last_clock_q <= 1'b0;
		end else if (accept) begin
			count_q      <= count_nx;
			phase_q      <= gen_nx.phase;
			shift_q      <= shift_nx;
			prescale_q   <= prescale_nx;
			last_clock_q <= clock_level;
		end
	end

`include "psg_tone_noise_generator_assert.svh"

	`PSG_ASSERT(a_noise_nonzero, shift_q != '0)
	`PSG_ASSERT(a_prescale_range, prescale_q <= PreW'(NoiseDivide))
	`PSG_ASSERT_NEXT(a_hold_when_idle, !accept, $stable(last_clock_q) && $stable(shift_q))

endmodule

// ----- hdl/psg_mix.sv -----
module psg_mix (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  psg_pkg::psg_regs_t regs_nx,
	input  psg_pkg::psg_gen_t  gen_nx,
	output logic               in_ready,
	psg_out_if.source          audio
);

	localparam int SumW = psg_pkg::AMP_W + 2;

	logic [psg_pkg::AMP_W-1:0]   amp_s1 [psg_pkg::NUM_CH];
	logic                         edge_s1;
	logic                         valid_s1;
	logic                         out_valid_q;
	logic [psg_pkg::LEVEL_W-1:0] level_q;
	logic [SumW-1:0]              sum;
	logic                         advance;

	assign advance  = !out_valid_q || audio.ready;
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		sum = '0;
		for (int c = 0; c < psg_pkg::NUM_CH; c++) begin
			sum = sum + SumW'(amp_s1[c]);
		end
	end

	// pick up amplitudes of the channels that are high after this sample
	always_ff @(posedge clk) begin
		if (accept) begin
			edge_s1 <= gen_nx.edge_hit;
			for (int c = 0; c < psg_pkg::NUM_CH; c++) begin
				amp_s1[c] <= gen_nx.phase[c] ? psg_pkg::AMP_TABLE[regs_nx.atten[c]] : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			level_q     <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
				// level persists across samples without a clock edge
				if (valid_s1 && edge_s1) begin
					level_q <= psg_pkg::LEVEL_W'({sum[SumW-1:2], 1'b0});
				end
			end
		end
	end

	assign audio.valid       = out_valid_q;
	assign audio.audio_level = level_q;

`include "psg_tone_noise_generator_assert.svh"

	`PSG_ASSERT(a_level_even, level_q[0] == 1'b0)
	`PSG_ASSERT(a_ready_when_drained, !out_valid_q |-> in_ready)
	`PSG_ASSERT_NEXT(a_level_only_on_edge, !(valid_s1 && advance && edge_s1), $stable(level_q))
	`PSG_ASSERT_NEXT(a_stage_filled, accept, valid_s1)

endmodule

// ----- hdl/psg_tone_noise_generator.sv -----
// Channel   Dir  Payload                                          Transfer
// sample    in   clock_level, chip_enable_n, write_enable_n, bus   valid && ready
// audio     out  audio_level[15:0]                                valid && ready
//
// One sample is taken per cycle while sample.ready is high.
// Bus write, tone counters and noise register update in the cycle of the transfer;
// the amplitude stage and the mix adder follow as two registers.
// Reset (arst_n low) clears all registers but the unreset amplitude stage; noise reseeds to 0x8000.
// A stalled audio output holds the result; one more sample fits in the amplitude stage.
module psg_tone_noise_generator #(
	parameter int NoiseDivide = psg_pkg::NOISE_DIVIDE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	psg_in_if.sink     sample,
	psg_out_if.source  audio
);

	psg_pkg::psg_regs_t regs_nx;
	psg_pkg::psg_gen_t  gen_nx;
	logic               accept;
	logic               in_ready;

	assign sample.ready = in_ready;
	assign accept       = sample.valid && in_ready;

	psg_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.write_en (!sample.chip_enable_n && !sample.write_enable_n),
		.bus_data (sample.bus_data),
		.regs_nx  (regs_nx)
	);

	psg_gen #(
		.NoiseDivide (NoiseDivide)
	) u_gen (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.clock_level (sample.clock_level),
		.regs_nx     (regs_nx),
		.gen_nx      (gen_nx)
	);

	psg_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.regs_nx  (regs_nx),
		.gen_nx   (gen_nx),
		.in_ready (in_ready),
		.audio    (audio)
	);

endmodule
